// File: src/scanline_event_scheduler_macros.svh
// Assertion helpers for the scanline event scheduler.
`ifndef SCANLINE_EVENT_SCHEDULER_MACROS_SVH
`define SCANLINE_EVENT_SCHEDULER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SES_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("scheduler check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SES_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("scheduler check failed");

`endif

// File: src/ses_pkg.sv
`default_nettype none

package ses_pkg;

	localparam int MAX_EVENTS   = 16;
	localparam int RESULT_LIMIT = 16;
	localparam int CNT_W        = $clog2(MAX_EVENTS + 1);
	localparam int IDX_W        = (MAX_EVENTS > 1) ? $clog2(MAX_EVENTS) : 1;
	localparam int NRES_W       = (RESULT_LIMIT > 1) ? $clog2(RESULT_LIMIT) : 1;

	typedef enum logic [2:0] {
		OP_ADD      = 3'd0,
		OP_REMOVE   = 3'd1,
		OP_RM_HNDLR = 3'd2,
		OP_CLEAR    = 3'd3,
		OP_FRAME    = 3'd4,
		OP_MATCH    = 3'd5
	} op_t;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_INSERT,
		CELL_DEL_EXACT,
		CELL_DEL_HNDLR
	} cell_cmd_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_RMALL,
		S_FINISH,
		S_FIRE
	} state_t;

	typedef struct packed {
		logic [7:0] line;
		logic [7:0] handler;
	} entry_t;

	// Signals rippling from one cell to the next one up the row.
	typedef struct packed {
		logic le;   // this cell and all below hold a line not above the key
		logic hit;  // a deletion match exists at or below this cell
	} cell_link_t;

endpackage

`default_nettype wire

// File: src/ses_cell.sv
`default_nettype none

module ses_cell (
	input  wire logic                clk,
	input  wire ses_pkg::cell_cmd_t  cmd,
	input  wire ses_pkg::entry_t     key,
	input  wire logic                occupied,
	input  wire ses_pkg::entry_t     prev_entry,
	input  wire ses_pkg::cell_link_t prev_link,
	input  wire ses_pkg::entry_t     next_entry,
	output ses_pkg::entry_t          entry,
	output ses_pkg::cell_link_t      link,
	output logic                     eq_next
);

	ses_pkg::entry_t entry_q;
	logic            match;

	always_comb begin
		case (cmd)
			ses_pkg::CELL_DEL_EXACT: match = occupied && (entry_q.line == key.line) &&
				(entry_q.handler == key.handler);
			ses_pkg::CELL_DEL_HNDLR: match = occupied && (entry_q.handler == key.handler);
			default: match = 1'b0;
		endcase
		link.le  = occupied && (entry_q.line <= key.line);
		link.hit = prev_link.hit || match;
	end

	// Insert: cells above the insertion point take their lower neighbor,
	// the cell at the point takes the new entry. Delete: cells at and above
	// the first match take their upper neighbor.
	always_ff @(posedge clk) begin
		case (cmd)
			ses_pkg::CELL_INSERT: begin
				if (!link.le) begin
					entry_q <= prev_link.le ? key : prev_entry;
				end
			end
			ses_pkg::CELL_DEL_EXACT, ses_pkg::CELL_DEL_HNDLR: begin
				if (link.hit) begin
					entry_q <= next_entry;
				end
			end
			default: begin
			end
		endcase
	end

	assign entry   = entry_q;
	assign eq_next = (entry_q.line == next_entry.line);

endmodule

`default_nettype wire

// File: src/scanline_event_scheduler.sv
// Scanline event scheduler: a line-sorted table of (scanline, handler) events.
// Command channel: opcode, line and handler transfer when cmd_valid is high and
// cmd_stall is low. Result channel: status, fire_valid, fired_handler, last,
// compare_write, compare_line, irq_enable and irq_flag_clear transfer when
// res_valid is high and res_stall is low. last marks the final result of a command.
// One command is worked on at a time; cmd_stall is high from the transfer until
// its final result has been loaded into the output register.
// Remove-for-handler works through the cell row, which deletes one entry per
// cycle. A line match gives one fired handler per cycle, read from the single
// cursor port on the row, as long as the output slot is free.
// A new command may transfer while the previous result still waits in the
// output register. When the receiver stalls, the result holds and the sequencer
// waits for the output slot before producing the next result.
// Reset empties the table, rewinds the cursor and clears the interrupt enable;
// the entry storage itself is not cleared.
`default_nettype none

`include "scanline_event_scheduler_macros.svh"

module scanline_event_scheduler (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cmd_valid,
	output logic            cmd_stall,
	input  wire logic [2:0] opcode,
	input  wire logic [7:0] line,
	input  wire logic [7:0] handler,
	output logic            res_valid,
	input  wire logic       res_stall,
	output logic            status,
	output logic            fire_valid,
	output logic [7:0]      fired_handler,
	output logic            last,
	output logic            compare_write,
	output logic [7:0]      compare_line,
	output logic            irq_enable,
	output logic            irq_flag_clear
);

	localparam int MAX = ses_pkg::MAX_EVENTS;

	// Sequencer state.
	ses_pkg::state_t               state_q, state_d;
	logic [ses_pkg::CNT_W-1:0]     count_q, count_d;
	logic [ses_pkg::CNT_W-1:0]     cursor_q, cursor_d;
	logic                          enable_q, enable_d;
	logic                          found_q, found_d;
	logic [ses_pkg::NRES_W-1:0]    nres_q, nres_d;
	ses_pkg::op_t                  op_q;
	ses_pkg::entry_t               key_q;

	// Output register.
	logic       res_valid_q;
	logic       status_q, fire_valid_q, last_q, cw_q, clr_q, en_q;
	logic [7:0] fired_q, cl_q;

	// Result being produced in this cycle.
	logic       emit;
	logic       r_status, r_fire, r_last, r_cw, r_clr;
	logic [7:0] r_fired, r_cl;

	// Cell row.
	ses_pkg::cell_cmd_t  cell_cmd;
	ses_pkg::entry_t     entry_v [MAX];
	ses_pkg::entry_t     next_v  [MAX];
	ses_pkg::entry_t     prev_v  [MAX];
	ses_pkg::cell_link_t link_v  [MAX+1];
	logic                eq_next_v [MAX];
	logic                occ_v     [MAX];

	logic                      cmd_xfer;
	logic                      slot_free;
	logic [ses_pkg::IDX_W-1:0] cur_idx;
	logic [ses_pkg::CNT_W-1:0] cur_plus1;
	logic                      fire_last;

	assign link_v[0] = '{le: 1'b1, hit: 1'b0};

	for (genvar i = 0; i < MAX; i++) begin : g_cell
		assign occ_v[i] = (count_q > ses_pkg::CNT_W'(i));
		if (i == 0) begin : g_bottom
			assign prev_v[i] = key_q;
		end else begin : g_inner_prev
			assign prev_v[i] = entry_v[i-1];
		end
		if (i == MAX - 1) begin : g_top
			assign next_v[i] = entry_v[i];
		end else begin : g_inner_next
			assign next_v[i] = entry_v[i+1];
		end
		ses_cell u_cell (
			.clk        (clk),
			.cmd        (cell_cmd),
			.key        (key_q),
			.occupied   (occ_v[i]),
			.prev_entry (prev_v[i]),
			.prev_link  (link_v[i]),
			.next_entry (next_v[i]),
			.entry      (entry_v[i]),
			.link       (link_v[i+1]),
			.eq_next    (eq_next_v[i])
		);
	end

	assign cmd_stall = (state_q != ses_pkg::S_IDLE);
	assign cmd_xfer  = cmd_valid && !cmd_stall;
	assign slot_free = !res_valid_q || !res_stall;
	assign cur_idx   = cursor_q[ses_pkg::IDX_W-1:0];
	assign cur_plus1 = cursor_q + ses_pkg::CNT_W'(1);
	// The run ends at the table's end, at a change of line, or at the result limit.
	assign fire_last = (cur_plus1 >= count_q) || !eq_next_v[cur_idx] ||
		(nres_q == ses_pkg::NRES_W'(ses_pkg::RESULT_LIMIT - 1));

	always_comb begin
		state_d   = state_q;
		count_d   = count_q;
		cursor_d  = cursor_q;
		enable_d  = enable_q;
		found_d   = found_q;
		nres_d    = nres_q;
		cell_cmd  = ses_pkg::CELL_HOLD;
		emit      = 1'b0;
		r_status  = 1'b0;
		r_fire    = 1'b0;
		r_fired   = 8'd0;
		r_last    = 1'b1;
		r_cw      = 1'b0;
		r_cl      = 8'd0;
		r_clr     = 1'b0;

		case (state_q)
			ses_pkg::S_IDLE: begin
				if (cmd_xfer) begin
					state_d = ses_pkg::S_EXEC;
				end
			end

			ses_pkg::S_EXEC: begin
				case (op_q)
					ses_pkg::OP_ADD: begin
						if (slot_free) begin
							emit    = 1'b1;
							state_d = ses_pkg::S_IDLE;
							if (key_q.handler != 8'd0 &&
								count_q != ses_pkg::CNT_W'(MAX)) begin
								cell_cmd = ses_pkg::CELL_INSERT;
								count_d  = count_q + ses_pkg::CNT_W'(1);
								enable_d = 1'b1;
								r_status = 1'b1;
							end
						end
					end
					ses_pkg::OP_REMOVE: begin
						cell_cmd = ses_pkg::CELL_DEL_EXACT;
						found_d  = link_v[MAX].hit;
						if (link_v[MAX].hit) begin
							count_d = count_q - ses_pkg::CNT_W'(1);
						end
						state_d = ses_pkg::S_FINISH;
					end
					ses_pkg::OP_RM_HNDLR: begin
						if (key_q.handler == 8'd0) begin
							if (slot_free) begin
								emit    = 1'b1;
								state_d = ses_pkg::S_IDLE;
							end
						end else begin
							found_d = 1'b0;
							state_d = ses_pkg::S_RMALL;
						end
					end
					ses_pkg::OP_CLEAR: begin
						if (slot_free) begin
							emit     = 1'b1;
							count_d  = '0;
							cursor_d = '0;
							enable_d = 1'b0;
							r_clr    = 1'b1;
							state_d  = ses_pkg::S_IDLE;
						end
					end
					ses_pkg::OP_FRAME: begin
						if (slot_free) begin
							emit     = 1'b1;
							cursor_d = '0;
							r_cw     = (count_q != '0);
							r_cl     = (count_q != '0) ? entry_v[0].line : 8'd0;
							state_d  = ses_pkg::S_IDLE;
						end
					end
					ses_pkg::OP_MATCH: begin
						if (cursor_q >= count_q) begin
							if (slot_free) begin
								emit    = 1'b1;
								state_d = ses_pkg::S_IDLE;
							end
						end else begin
							nres_d  = '0;
							state_d = ses_pkg::S_FIRE;
						end
					end
					default: begin
						if (slot_free) begin
							emit    = 1'b1;
							state_d = ses_pkg::S_IDLE;
						end
					end
				endcase
			end

			// One matching entry leaves the row per cycle until none is left.
			ses_pkg::S_RMALL: begin
				cell_cmd = ses_pkg::CELL_DEL_HNDLR;
				if (link_v[MAX].hit) begin
					count_d = count_q - ses_pkg::CNT_W'(1);
					found_d = 1'b1;
				end else begin
					state_d = ses_pkg::S_FINISH;
				end
			end

			ses_pkg::S_FINISH: begin
				if (slot_free) begin
					emit     = 1'b1;
					cursor_d = '0;
					r_status = found_q;
					if (count_q == '0) begin
						enable_d = 1'b0;
						r_clr    = 1'b1;
					end else begin
						enable_d = 1'b1;
						r_cw     = 1'b1;
						r_cl     = entry_v[0].line;
					end
					state_d = ses_pkg::S_IDLE;
				end
			end

			ses_pkg::S_FIRE: begin
				if (slot_free) begin
					emit     = 1'b1;
					r_fire   = 1'b1;
					r_fired  = entry_v[cur_idx].handler;
					r_last   = fire_last;
					cursor_d = cur_plus1;
					nres_d   = nres_q + ses_pkg::NRES_W'(1);
					if (fire_last) begin
						r_cw    = (cur_plus1 < count_q);
						r_cl    = (cur_plus1 < count_q) ? next_v[cur_idx].line : 8'd0;
						state_d = ses_pkg::S_IDLE;
					end
				end
			end

			default: begin
				state_d = ses_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ses_pkg::S_IDLE;
			count_q     <= '0;
			cursor_q    <= '0;
			enable_q    <= 1'b0;
			found_q     <= 1'b0;
			nres_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			count_q  <= count_d;
			cursor_q <= cursor_d;
			enable_q <= enable_d;
			found_q  <= found_d;
			nres_q   <= nres_d;
			if (emit) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// Command and result payload registers.
	always_ff @(posedge clk) begin
		if (cmd_xfer) begin
			op_q  <= ses_pkg::op_t'(opcode);
			key_q <= '{line: line, handler: handler};
		end
		if (emit) begin
			status_q     <= r_status;
			fire_valid_q <= r_fire;
			fired_q      <= r_fired;
			last_q       <= r_last;
			cw_q         <= r_cw;
			cl_q         <= r_cl;
			en_q         <= enable_d;
			clr_q        <= r_clr;
		end
	end

	assign res_valid      = res_valid_q;
	assign status         = status_q;
	assign fire_valid     = fire_valid_q;
	assign fired_handler  = fired_q;
	assign last           = last_q;
	assign compare_write  = cw_q;
	assign compare_line   = cl_q;
	assign irq_enable     = en_q;
	assign irq_flag_clear = clr_q;

	// A transferred command always starts the sequencer.
	`SES_ASSERT_NEXT(a_xfer_starts, clk, arst_n, cmd_xfer, state_q != ses_pkg::S_IDLE)
	// Firing only reads entries that are present in the table.
	`SES_ASSERT_IMPL(a_fire_in_table, clk, arst_n, state_q == ses_pkg::S_FIRE, cursor_q < count_q)
	// The table never holds more than its capacity.
	`SES_ASSERT_IMPL(a_count_cap, clk, arst_n, 1'b1, count_q <= ses_pkg::CNT_W'(MAX))

endmodule

`default_nettype wire

// File: bench/scanline_event_scheduler_test.sv
`default_nettype none

module scanline_event_scheduler_test;
	timeunit 1ns;
	timeprecision 1ps;

	// The package names only the six defined opcodes. The two spare codes are
	// named here so that the stimulus never writes a bare opcode value.
	localparam logic [2:0] OP_SPARE6 = 3'd6;
	localparam logic [2:0] OP_SPARE7 = 3'd7;

	// This drain period covers any result that might still come after the
	// last one we expect.
	localparam int DRAIN_CYCLES = ses_pkg::MAX_EVENTS + 8;
	localparam int RANDOM_ITEMS = 280;

	// One result transfer as the block presents it on its output ports.
	typedef struct packed {
		logic       status;
		logic       fire_valid;
		logic [7:0] fired_handler;
		logic       last;
		logic       compare_write;
		logic [7:0] compare_line;
		logic       irq_enable;
		logic       irq_flag_clear;
	} sched_result_t;

	logic       clk;
	logic       arst_n;
	logic       cmd_valid;
	logic       cmd_stall;
	logic [2:0] opcode;
	logic [7:0] line;
	logic [7:0] handler;
	logic       res_valid;
	logic       res_stall;
	logic       status;
	logic       fire_valid;
	logic [7:0] fired_handler;
	logic       last;
	logic       compare_write;
	logic [7:0] compare_line;
	logic       irq_enable;
	logic       irq_flag_clear;

	scanline_event_scheduler u_top (.*);

	// Our own copy of the event table. It is updated when a command transfer
	// is accepted, so it always matches what the block should hold by then.
	logic [7:0] ev_line [ses_pkg::MAX_EVENTS];
	logic [7:0] ev_hnd [ses_pkg::MAX_EVENTS];
	int         ev_count;
	int         ev_cursor;
	logic       ev_enable;

	// Results that the block still owes us, oldest first.
	sched_result_t awaited_results[$];

	int errors;
	int items_sent;
	// While this is set, neither side inserts idle cycles. It flips now and
	// then so that the run has stretches of back-to-back transfers.
	bit quiet;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Build one result. The interrupt enable always reflects the table state
	// after the command has taken effect.
	function automatic sched_result_t make_result(input logic st, input logic fv,
			input logic [7:0] fh, input logic lst, input logic cw,
			input logic [7:0] cl, input logic clr);
		sched_result_t r;
		r.status         = st;
		r.fire_valid     = fv;
		r.fired_handler  = fh;
		r.last           = lst;
		r.compare_write  = cw;
		r.compare_line   = cl;
		r.irq_enable     = ev_enable;
		r.irq_flag_clear = clr;
		return r;
	endfunction

	// Close the gap left by a deleted entry.
	function automatic void drop_entry(input int idx);
		for (int i = idx; i + 1 < ev_count; i++) begin
			ev_line[i] = ev_line[i + 1];
			ev_hnd[i]  = ev_hnd[i + 1];
		end
		ev_count--;
	endfunction

	// Both removals rewind the cursor. An emptied table turns the line
	// interrupt off and clears its flag; otherwise the first line is reloaded.
	function automatic void close_removal(input logic found);
		ev_cursor = 0;
		if (ev_count == 0) begin
			ev_enable = 1'b0;
			awaited_results.push_back(make_result(found, 1'b0, 8'd0, 1'b1, 1'b0, 8'd0,
				1'b1));
		end else begin
			ev_enable = 1'b1;
			awaited_results.push_back(make_result(found, 1'b0, 8'd0, 1'b1, 1'b1,
				ev_line[0], 1'b0));
		end
	endfunction

	// Apply one accepted command to the table copy and queue the results
	// that it must produce.
	function automatic void schedule_step(input logic [2:0] op, input logic [7:0] ln,
			input logic [7:0] hd);
		int            pos;
		int            idx;
		logic          found;
		sched_result_t r;
		case (op)
			ses_pkg::OP_ADD: begin
				// Handler zero and a full table are refused without any change.
				if (hd == 8'd0 || ev_count >= ses_pkg::MAX_EVENTS) begin
					awaited_results.push_back(make_result(1'b0, 1'b0, 8'd0, 1'b1, 1'b0,
						8'd0, 1'b0));
				end else begin
					// The new entry goes after every entry whose line is not larger.
					pos = 0;
					while (pos < ev_count && ev_line[pos] <= ln)
						pos++;
					for (idx = ev_count; idx > pos; idx--) begin
						ev_line[idx] = ev_line[idx - 1];
						ev_hnd[idx]  = ev_hnd[idx - 1];
					end
					ev_line[pos] = ln;
					ev_hnd[pos]  = hd;
					ev_count++;
					ev_enable = 1'b1;
					awaited_results.push_back(make_result(1'b1, 1'b0, 8'd0, 1'b1, 1'b0,
						8'd0, 1'b0));
				end
			end
			ses_pkg::OP_REMOVE: begin
				found = 1'b0;
				idx   = 0;
				while (!found && idx < ev_count) begin
					if (ev_line[idx] == ln && ev_hnd[idx] == hd) begin
						drop_entry(idx);
						found = 1'b1;
					end else begin
						idx++;
					end
				end
				close_removal(found);
			end
			ses_pkg::OP_RM_HNDLR: begin
				if (hd == 8'd0) begin
					awaited_results.push_back(make_result(1'b0, 1'b0, 8'd0, 1'b1, 1'b0,
						8'd0, 1'b0));
				end else begin
					found = 1'b0;
					idx   = 0;
					while (idx < ev_count) begin
						if (ev_hnd[idx] == hd) begin
							drop_entry(idx);
							found = 1'b1;
						end else begin
							idx++;
						end
					end
					close_removal(found);
				end
			end
			ses_pkg::OP_CLEAR: begin
				ev_count  = 0;
				ev_cursor = 0;
				ev_enable = 1'b0;
				awaited_results.push_back(make_result(1'b0, 1'b0, 8'd0, 1'b1, 1'b0, 8'd0,
					1'b1));
			end
			ses_pkg::OP_FRAME: begin
				ev_cursor = 0;
				if (ev_count != 0)
					awaited_results.push_back(make_result(1'b0, 1'b0, 8'd0, 1'b1, 1'b1,
						ev_line[0], 1'b0));
				else
					awaited_results.push_back(make_result(1'b0, 1'b0, 8'd0, 1'b1, 1'b0,
						8'd0, 1'b0));
			end
			ses_pkg::OP_MATCH: begin
				if (ev_cursor >= ev_count) begin
					awaited_results.push_back(make_result(1'b0, 1'b0, 8'd0, 1'b1, 1'b0,
						8'd0, 1'b0));
				end else begin
					// Find the end of the run of equal lines, capped at the
					// number of results one command may produce.
					idx = ev_cursor;
					while (idx < ev_count && ev_line[idx] == ev_line[ev_cursor]
							&& idx - ev_cursor < ses_pkg::RESULT_LIMIT)
						idx++;
					for (pos = ev_cursor; pos < idx; pos++) begin
						r = make_result(1'b0, 1'b1, ev_hnd[pos], pos == idx - 1, 1'b0,
							8'd0, 1'b0);
						// The final firing loads the line of the next entry, if any.
						if (pos == idx - 1 && idx < ev_count) begin
							r.compare_write = 1'b1;
							r.compare_line  = ev_line[idx];
						end
						awaited_results.push_back(r);
					end
					ev_cursor = idx;
				end
			end
			default: begin
				awaited_results.push_back(make_result(1'b0, 1'b0, 8'd0, 1'b1, 1'b0, 8'd0,
					1'b0));
			end
		endcase
	endfunction

	// Send one command. After a random number of idle cycles the command is
	// presented at a falling edge and held until a rising edge accepts the
	// transfer. Valid is left high so that a following command with no gap
	// goes out back to back; wait_idle lowers it.
	task automatic send_cmd(input logic [2:0] op, input logic [7:0] ln, input logic [7:0] hd);
		int gap;
		if ($urandom_range(0, 39) == 0)
			quiet = !quiet;
		gap = quiet ? 0 : $urandom_range(0, 5);
		@(negedge clk);
		if (gap > 0) begin
			// The payload carries junk while valid is low.
			cmd_valid <= 1'b0;
			opcode    <= 3'($urandom_range(0, 7));
			line      <= 8'($urandom_range(0, 255));
			handler   <= 8'($urandom_range(0, 255));
			repeat (gap) @(negedge clk);
		end
		cmd_valid <= 1'b1;
		opcode    <= op;
		line      <= ln;
		handler   <= hd;
		@(posedge clk);
		while (!(cmd_valid && cmd_stall === 1'b0))
			@(posedge clk);
		schedule_step(op, ln, hd);
		items_sent++;
	endtask

	// Stop sending and wait until every expected result has transferred.
	task automatic wait_idle();
		@(negedge clk);
		cmd_valid <= 1'b0;
		while (awaited_results.size() != 0)
			@(posedge clk);
	endtask

	// Field extremes, every opcode and each corner case on a small table.
	task automatic test_directed();
		send_cmd(ses_pkg::OP_FRAME, 8'd0, 8'd0);         // frame start on an empty table
		send_cmd(ses_pkg::OP_MATCH, 8'd0, 8'd0);         // line match with nothing left
		send_cmd(ses_pkg::OP_ADD, 8'd12, 8'd0);          // handler zero is refused
		send_cmd(ses_pkg::OP_ADD, 8'hFF, 8'hFF);
		send_cmd(ses_pkg::OP_ADD, 8'h00, 8'h01);
		send_cmd(ses_pkg::OP_ADD, 8'h80, 8'hAA);
		send_cmd(ses_pkg::OP_ADD, 8'h80, 8'h55);         // equal line lands after the first
		send_cmd(ses_pkg::OP_ADD, 8'h80, 8'hAA);         // duplicate entry
		send_cmd(ses_pkg::OP_FRAME, 8'hFF, 8'hFF);
		send_cmd(ses_pkg::OP_MATCH, 8'hFF, 8'hFF);
		send_cmd(ses_pkg::OP_MATCH, 8'h00, 8'h00);       // fires the three entries at 0x80
		send_cmd(ses_pkg::OP_MATCH, 8'h00, 8'h00);
		send_cmd(ses_pkg::OP_MATCH, 8'h00, 8'h00);       // cursor is past the end
		send_cmd(ses_pkg::OP_REMOVE, 8'h80, 8'h01);      // no exact match, still rewinds
		send_cmd(ses_pkg::OP_REMOVE, 8'h80, 8'hAA);      // removes only the first copy
		send_cmd(ses_pkg::OP_RM_HNDLR, 8'h80, 8'h00);    // handler zero is ignored
		send_cmd(ses_pkg::OP_RM_HNDLR, 8'h00, 8'h55);
		send_cmd(OP_SPARE6, 8'hFF, 8'hFF);
		send_cmd(OP_SPARE7, 8'h00, 8'h00);
		send_cmd(ses_pkg::OP_RM_HNDLR, 8'h00, 8'h42);    // handler not in the table
		send_cmd(ses_pkg::OP_REMOVE, 8'h00, 8'h01);
		send_cmd(ses_pkg::OP_REMOVE, 8'h80, 8'hAA);
		send_cmd(ses_pkg::OP_REMOVE, 8'hFF, 8'hFF);      // leaves the table empty
		send_cmd(ses_pkg::OP_ADD, 8'h33, 8'h7E);
		send_cmd(ses_pkg::OP_CLEAR, 8'hFF, 8'hFF);
	endtask

	// Fill the table with one line so that a single match fires the most
	// handlers, then check refusal of an add to a full table.
	task automatic test_full_table();
		send_cmd(ses_pkg::OP_CLEAR, 8'h00, 8'h00);
		for (int i = 1; i <= ses_pkg::MAX_EVENTS; i++)
			send_cmd(ses_pkg::OP_ADD, 8'h40, 8'(i));
		send_cmd(ses_pkg::OP_ADD, 8'h10, 8'h99);
		send_cmd(ses_pkg::OP_FRAME, 8'h00, 8'h00);
		send_cmd(ses_pkg::OP_MATCH, 8'h00, 8'h00);
		send_cmd(ses_pkg::OP_MATCH, 8'h00, 8'h00);
		send_cmd(ses_pkg::OP_RM_HNDLR, 8'h00, 8'd5);
		send_cmd(ses_pkg::OP_ADD, 8'h41, 8'h77);
		send_cmd(ses_pkg::OP_FRAME, 8'h00, 8'h00);
		send_cmd(ses_pkg::OP_MATCH, 8'h00, 8'h00);       // compare loads the next line
		send_cmd(ses_pkg::OP_MATCH, 8'h00, 8'h00);
	endtask

	// Random traffic. Most of it walks frames the way software would: a
	// frame start followed by line matches until the cursor runs off the
	// table, with edits in between. Lines and handlers come mostly from a
	// small range so that equal lines and repeated handlers are common.
	task automatic test_random_traffic();
		int         start;
		int         pick;
		int         idx;
		logic [7:0] ln;
		logic [7:0] hd;
		start = items_sent;
		while (items_sent - start < RANDOM_ITEMS) begin
			pick = $urandom_range(0, 99);
			ln = $urandom_range(0, 1) ? 8'($urandom_range(0, 7)) : 8'($urandom_range(0, 255));
			hd = $urandom_range(0, 1) ? 8'($urandom_range(1, 6)) : 8'($urandom_range(0, 255));
			if (pick < 30) begin
				send_cmd(ses_pkg::OP_ADD, ln, hd);
			end else if (pick < 42) begin
				// Remove an entry that exists, when there is one.
				if (ev_count > 0) begin
					idx = $urandom_range(0, ev_count - 1);
					send_cmd(ses_pkg::OP_REMOVE, ev_line[idx], ev_hnd[idx]);
				end else begin
					send_cmd(ses_pkg::OP_REMOVE, ln, hd);
				end
			end else if (pick < 47) begin
				send_cmd(ses_pkg::OP_REMOVE, ln, hd);
			end else if (pick < 55) begin
				if (ev_count > 0 && $urandom_range(0, 1))
					hd = ev_hnd[$urandom_range(0, ev_count - 1)];
				send_cmd(ses_pkg::OP_RM_HNDLR, ln, hd);
			end else if (pick < 58) begin
				send_cmd(ses_pkg::OP_CLEAR, ln, hd);
			end else if (pick < 85) begin
				send_cmd(ses_pkg::OP_FRAME, ln, hd);
				while (ev_cursor < ev_count && items_sent - start < RANDOM_ITEMS) begin
					if ($urandom_range(0, 9) == 0)
						send_cmd(ses_pkg::OP_ADD, 8'($urandom_range(0, 7)),
							8'($urandom_range(1, 6)));
					else
						send_cmd(ses_pkg::OP_MATCH, 8'($urandom_range(0, 255)),
							8'($urandom_range(0, 255)));
				end
				// Sometimes one more match after the cursor has run off the end.
				if ($urandom_range(0, 2) == 0)
					send_cmd(ses_pkg::OP_MATCH, ln, hd);
			end else if (pick < 93) begin
				send_cmd(ses_pkg::OP_MATCH, ln, hd);
			end else begin
				// Anything at all, spare opcodes included.
				send_cmd(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
					8'($urandom_range(0, 255)));
			end
		end
	endtask

	// Result side: before each result transfer, hold stall high for a random
	// number of cycles, then take the transfer as soon as it is offered.
	initial begin
		int hold;
		res_stall = 1'b0;
		forever begin
			hold = quiet ? 0 : $urandom_range(0, 5);
			if (hold > 0) begin
				@(negedge clk);
				res_stall <= 1'b1;
				repeat (hold) @(negedge clk);
				res_stall <= 1'b0;
			end
			@(posedge clk);
			while (!(res_valid === 1'b1 && res_stall === 1'b0))
				@(posedge clk);
		end
	end

	function automatic void compare_field(input string name, input logic [7:0] want,
			input logic [7:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endfunction

	// Every result transfer is checked against the oldest expectation.
	always @(posedge clk) begin
		sched_result_t want;
		if (arst_n === 1'b1 && res_valid === 1'b1 && res_stall === 1'b0) begin
			if (awaited_results.size() == 0) begin
				$error("result transfer with no result expected");
				errors++;
			end else begin
				want = awaited_results.pop_front();
				compare_field("status", want.status, status);
				compare_field("fire_valid", want.fire_valid, fire_valid);
				compare_field("fired_handler", want.fired_handler, fired_handler);
				compare_field("last", want.last, last);
				compare_field("compare_write", want.compare_write, compare_write);
				compare_field("compare_line", want.compare_line, compare_line);
				compare_field("irq_enable", want.irq_enable, irq_enable);
				compare_field("irq_flag_clear", want.irq_flag_clear, irq_flag_clear);
			end
		end
	end

	initial begin
		arst_n     = 1'b0;
		cmd_valid  = 1'b0;
		opcode     = ses_pkg::OP_ADD;
		line       = 8'd0;
		handler    = 8'd0;
		errors     = 0;
		items_sent = 0;
		quiet      = 1'b0;
		ev_count   = 0;
		ev_cursor  = 0;
		ev_enable  = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed();
		wait_idle();
		test_full_table();
		wait_idle();
		test_random_traffic();
		wait_idle();

		// Any result that turns up now has no expectation and is flagged.
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	// The slowest correct run is well under a millisecond of simulated time.
	initial begin
		#10_000_000;
		$display("== FAIL ==");
		$finish;
	end

endmodule

`default_nettype wire
